// ===== hdl/pwin_pkg.sv =====
// Shared types and constants for the 2-D pooling window block.
// Holds the sequencer state type, pooling mode codes and register indexes.
// Depends on nothing; imported by the top level and the testbench.
package pwin_pkg;

  localparam int MODE_BITS      = 2;
  localparam int WIN_BITS       = 3;
  localparam int SIZE_BITS      = 7;
  localparam int POS_BITS       = 6;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 7;

  localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_AVG = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_MODE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_SIZE    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_HEIGHT = 3'd4;

  localparam logic [WIN_BITS-1:0]  RST_WINDOW_SIZE  = 3'd2;
  localparam logic [WIN_BITS-1:0]  RST_STEP_SIZE    = 3'd2;
  localparam logic [SIZE_BITS-1:0] RST_PLANE_WIDTH  = 7'd28;
  localparam logic [SIZE_BITS-1:0] RST_PLANE_HEIGHT = 7'd28;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_DRAIN,
    ST_AVGGO,
    ST_AVG,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/pwin_div.sv =====
// Unsigned restoring divider that retires one quotient bit per cycle.
// Used for window positions and for the average; no package dependency.
module pwin_div #(
  parameter int N = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] num,
  input  logic [D-1:0] den,
  output logic         done,
  output logic [N-1:0] quo,
  output logic [D-1:0] rem
);

  localparam int CNT_BITS = $clog2(N + 1);

  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [D:0]          trial;
  logic [D:0]          diff;
  logic                ge;

  assign trial = {rem, quo[N-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(N);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[N-2:0], ge};
      rem <= ge ? diff[D-1:0] : trial[D-1:0];
    end
  end

endmodule

// ===== hdl/pooling_window_2d.sv =====
// Top level of the 2-D pooling window block: line store, sequencer, accumulator.
// Depends on pwin_pkg and on pwin_div for positions and the average.
//
// Pixels arrive on the input channel (in_valid, in_ready, pixel_in) in raster
// order, one plane after another. Results leave on the output channel
// (out_valid, out_ready, pooled_value, out_row, out_col, plane_done), one beat
// for each full window whose origin lies on the stride grid.
// Configuration is written through cfg_write, cfg_index and cfg_data while idle.
// A pixel that cannot close a window leaves the sequencer idle. A pixel past the
// first window row and column runs the position divider. A pixel that closes a
// window then reads the window one store entry per cycle through the single
// read port; for average, the sum divider then retires one bit per cycle.
// The result beat appears on the cycle after the sequencer finishes.
// The output register holds a result while the receiver stalls; the next pixel
// is still accepted, and the sequencer waits only if a new result is ready
// before the old beat is taken.
// Synchronous reset restores the register defaults and clears the row, column
// and slot counters; the line store holds undefined data until written.
module pooling_window_2d #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_WINDOW = 4,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pwin_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pwin_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [PIXEL_BITS-1:0]         pixel_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [PIXEL_BITS-1:0]         pooled_value,
  output logic [pwin_pkg::POS_BITS-1:0]        out_row,
  output logic [pwin_pkg::POS_BITS-1:0]        out_col,
  output logic                                 plane_done
);

  import pwin_pkg::*;

  localparam int SLOT_BITS    = $clog2(MAX_WINDOW);
  localparam int DEPTH        = MAX_WINDOW * MAX_WIDTH;
  localparam int ADDR_BITS    = $clog2(DEPTH);
  localparam int SUM_BITS     = PIXEL_BITS + $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam int AREA_BITS    = 2 * WIN_BITS;
  localparam int W_LIMIT_INT  = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam int WS_LIMIT_INT = (MAX_WINDOW < 7) ? MAX_WINDOW : 7;

  localparam logic [SIZE_BITS-1:0] W_LIMIT    = SIZE_BITS'(W_LIMIT_INT);
  localparam logic [WIN_BITS-1:0]  WS_LIMIT   = WIN_BITS'(WS_LIMIT_INT);
  localparam logic [SLOT_BITS-1:0] SLOT_LAST  = SLOT_BITS'(MAX_WINDOW - 1);
  localparam logic [ADDR_BITS-1:0] ROW_STRIDE = ADDR_BITS'(MAX_WIDTH);

  logic [MODE_BITS-1:0] pool_mode;
  logic [WIN_BITS-1:0]  window_size;
  logic [WIN_BITS-1:0]  step_size;
  logic [SIZE_BITS-1:0] plane_width;
  logic [SIZE_BITS-1:0] plane_height;

  logic [WIN_BITS-1:0]  ws;
  logic [WIN_BITS-1:0]  ws_m1;
  logic [WIN_BITS-1:0]  st;
  logic [SIZE_BITS-1:0] w_eff;
  logic [SIZE_BITS-1:0] h_eff;
  logic [AREA_BITS-1:0] area;

  logic [POS_BITS-1:0]  row_count;
  logic [SIZE_BITS-1:0] col_count;
  logic [SLOT_BITS-1:0] row_slot;
  logic [POS_BITS:0]    row_inc;
  logic [SIZE_BITS:0]   col_inc;

  state_t state;
  state_t state_next;

  logic accept;
  logic cand;
  logic pos_start;
  logic rd_en;
  logic rd_last;
  logic sum_start;
  logic load_out;

  logic [SIZE_BITS-1:0] rnum_in;
  logic [SIZE_BITS-1:0] cnum_in;
  logic [SIZE_BITS-1:0] rnum;
  logic [SIZE_BITS-1:0] cnum;
  logic [SIZE_BITS-1:0] pix_col;
  logic [SLOT_BITS-1:0] pix_slot;

  logic                 row_done;
  logic                 col_done;
  logic [SIZE_BITS-1:0] row_quo;
  logic [SIZE_BITS-1:0] col_quo;
  logic [WIN_BITS-1:0]  row_rem;
  logic [WIN_BITS-1:0]  col_rem;

  logic [SIZE_BITS:0] hspan;
  logic [SIZE_BITS:0] wspan;
  logic               last_now;
  logic               plane_last;

  logic [PIXEL_BITS-1:0] store [DEPTH];
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  rd_vld;

  logic [WIN_BITS-1:0]  kk;
  logic [WIN_BITS-1:0]  jj;
  logic [SLOT_BITS-1:0] rslot;
  logic [SIZE_BITS-1:0] rcol;

  logic signed [SUM_BITS-1:0] acc;
  logic signed [SUM_BITS-1:0] rd_ext;
  logic                       acc_first;
  logic [SUM_BITS-1:0]        acc_mag;
  logic                       sum_done;
  logic [SUM_BITS-1:0]        sum_quo;
  logic [SUM_BITS-1:0]        avg_val;
  logic [PIXEL_BITS-1:0]      result;

  always_comb begin
    if (window_size == '0) begin
      ws = WIN_BITS'(1);
    end else if (window_size > WS_LIMIT) begin
      ws = WS_LIMIT;
    end else begin
      ws = window_size;
    end
    st = (step_size == '0) ? WIN_BITS'(1) : step_size;
    if (plane_width == '0) begin
      w_eff = SIZE_BITS'(1);
    end else if (plane_width > W_LIMIT) begin
      w_eff = W_LIMIT;
    end else begin
      w_eff = plane_width;
    end
    if (plane_height == '0) begin
      h_eff = SIZE_BITS'(1);
    end else if (plane_height > W_LIMIT) begin
      h_eff = W_LIMIT;
    end else begin
      h_eff = plane_height;
    end
  end

  assign ws_m1   = ws - WIN_BITS'(1);
  assign area    = AREA_BITS'(ws) * AREA_BITS'(ws);
  assign row_inc = {1'b0, row_count} + (POS_BITS + 1)'(1);
  assign col_inc = {1'b0, col_count} + (SIZE_BITS + 1)'(1);
  assign cand    = (row_inc >= (POS_BITS + 1)'(ws)) && (col_inc >= (SIZE_BITS + 1)'(ws));
  assign rnum_in = SIZE_BITS'(row_inc - (POS_BITS + 1)'(ws));
  assign cnum_in = SIZE_BITS'(col_inc - (SIZE_BITS + 1)'(ws));
  assign accept  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode    <= MODE_MAX;
      window_size  <= RST_WINDOW_SIZE;
      step_size    <= RST_STEP_SIZE;
      plane_width  <= RST_PLANE_WIDTH;
      plane_height <= RST_PLANE_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POOL_MODE:    pool_mode    <= cfg_data[MODE_BITS-1:0];
        REG_WINDOW_SIZE:  window_size  <= cfg_data[WIN_BITS-1:0];
        REG_STEP_SIZE:    step_size    <= cfg_data[WIN_BITS-1:0];
        REG_PLANE_WIDTH:  plane_width  <= cfg_data;
        REG_PLANE_HEIGHT: plane_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      row_slot  <= '0;
    end else if (accept) begin
      if (col_inc >= {1'b0, w_eff}) begin
        col_count <= '0;
        if ({1'b0, row_inc} >= {1'b0, h_eff}) begin
          row_count <= '0;
          row_slot  <= '0;
        end else begin
          row_count <= row_inc[POS_BITS-1:0];
          row_slot  <= (row_slot == SLOT_LAST) ? '0 : row_slot + SLOT_BITS'(1);
        end
      end else begin
        col_count <= col_inc[SIZE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rnum     <= rnum_in;
      cnum     <= cnum_in;
      pix_col  <= col_count;
      pix_slot <= row_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cand) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (row_done) begin
          state_next = (row_rem == '0 && col_rem == '0) ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        if (rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = (pool_mode == MODE_AVG) ? ST_AVGGO : ST_FINISH;
      end
      ST_AVGGO: begin
        state_next = ST_AVG;
      end
      ST_AVG: begin
        if (sum_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    sum_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:   in_ready  = 1'b1;
      ST_READ:   rd_en     = 1'b1;
      ST_AVGGO:  sum_start = 1'b1;
      ST_FINISH: load_out  = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign pos_start = accept && cand;
  assign rd_last   = (kk == ws_m1) && (jj == ws_m1);

  pwin_div #(
    .N(SIZE_BITS),
    .D(WIN_BITS)
  ) u_row_div (
    .clk(clk),
    .rst(rst),
    .start(pos_start),
    .num(rnum_in),
    .den(st),
    .done(row_done),
    .quo(row_quo),
    .rem(row_rem)
  );

  pwin_div #(
    .N(SIZE_BITS),
    .D(WIN_BITS)
  ) u_col_div (
    .clk(clk),
    .rst(rst),
    .start(pos_start),
    .num(cnum_in),
    .den(st),
    .done(col_done),
    .quo(col_quo),
    .rem(col_rem)
  );

  assign hspan    = {1'b0, h_eff} - (SIZE_BITS + 1)'(ws);
  assign wspan    = {1'b0, w_eff} - (SIZE_BITS + 1)'(ws);
  assign last_now = (h_eff >= SIZE_BITS'(ws)) && (w_eff >= SIZE_BITS'(ws)) &&
                    ({1'b0, rnum} <= hspan) &&
                    (hspan < {1'b0, rnum} + (SIZE_BITS + 1)'(st)) &&
                    ({1'b0, cnum} <= wspan) &&
                    (wspan < {1'b0, cnum} + (SIZE_BITS + 1)'(st));

  always_ff @(posedge clk) begin
    if (state == ST_DIV && row_done) begin
      plane_last <= last_now;
    end
  end

  assign wr_addr = ADDR_BITS'(row_slot) * ROW_STRIDE + ADDR_BITS'(col_count);
  assign rd_addr = ADDR_BITS'(rslot) * ROW_STRIDE + ADDR_BITS'(rcol);

  always_ff @(posedge clk) begin
    if (accept) begin
      store[wr_addr] <= pixel_in;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      kk    <= '0;
      jj    <= '0;
      rslot <= pix_slot;
      rcol  <= pix_col;
    end else if (rd_en) begin
      if (jj == ws_m1) begin
        jj    <= '0;
        kk    <= kk + WIN_BITS'(1);
        rslot <= (rslot == '0) ? SLOT_LAST : rslot - SLOT_BITS'(1);
        rcol  <= pix_col;
      end else begin
        jj   <= jj + WIN_BITS'(1);
        rcol <= rcol - SIZE_BITS'(1);
      end
    end
  end

  assign rd_ext = {{(SUM_BITS - PIXEL_BITS){rd_data[PIXEL_BITS-1]}}, rd_data};

  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      acc_first <= 1'b1;
    end else if (rd_vld) begin
      acc_first <= 1'b0;
      if (acc_first) begin
        acc <= rd_ext;
      end else begin
        case (pool_mode)
          MODE_MIN: begin
            if (rd_ext < acc) begin
              acc <= rd_ext;
            end
          end
          MODE_AVG: acc <= acc + rd_ext;
          default: begin
            if (rd_ext > acc) begin
              acc <= rd_ext;
            end
          end
        endcase
      end
    end
  end

  assign acc_mag = acc[SUM_BITS-1] ? SUM_BITS'(-acc) : SUM_BITS'(acc);

  pwin_div #(
    .N(SUM_BITS),
    .D(AREA_BITS)
  ) u_sum_div (
    .clk(clk),
    .rst(rst),
    .start(sum_start),
    .num(acc_mag),
    .den(area),
    .done(sum_done),
    .quo(sum_quo),
    .rem()
  );

  assign avg_val = acc[SUM_BITS-1] ? (~sum_quo + SUM_BITS'(1)) : sum_quo;
  assign result  = (pool_mode == MODE_AVG) ? avg_val[PIXEL_BITS-1:0] : acc[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pooled_value <= result;
      out_row      <= row_quo[POS_BITS-1:0];
      out_col      <= col_quo[POS_BITS-1:0];
      plane_done   <= plane_last;
    end
  end

`ifndef SYNTH
  a_pos_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    row_done == col_done)
    else $error("Row and column position dividers finished apart.");

  a_short_pixel: assert property (@(posedge clk) disable iff (rst)
    (accept && !cand) |=> in_ready)
    else $error("A pixel that closes no window held the input channel.");

  a_read_window: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_READ || state == ST_DRAIN))
    else $error("Store read data arrived outside the window read.");

  a_sum_done_state: assert property (@(posedge clk) disable iff (rst)
    sum_done |-> state == ST_AVG)
    else $error("Average divider finished while the sequencer was elsewhere.");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("A loaded result beat was not offered.");
`endif

endmodule

// ===== tb/tb_pooling_window_2d.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pooling_window_2d: directed pixel script, then random planes.
// Every result beat is checked against a scripted value or a predictor of the pooling behavior; needs pwin_pkg.
module tb_pooling_window_2d;
  import pwin_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int WIN_MAX       = 4;
  localparam int ROW_MAX       = 64;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 600;
  localparam int STALL_LIMIT   = 4000;
  localparam int PIXEL_TARGET  = 1050;
  localparam int STEADY_TAIL   = 150;

  localparam logic [MODE_BITS-1:0]      MODE_ALIAS_MAX = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE      = 3'd5;

  typedef struct packed {
    logic [15:0]         value;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                done;
  } pool_result_t;

  typedef struct packed {
    logic                      is_reg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic [15:0]               px;
    logic                      typed;
    pool_result_t              want;
  } script_row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [15:0]        pixel_in;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [15:0]        pooled_value;
  logic [POS_BITS-1:0]       out_row;
  logic [POS_BITS-1:0]       out_col;
  logic                      plane_done;

  pooling_window_2d dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_in(pixel_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pooled_value(pooled_value),
    .out_row(out_row),
    .out_col(out_col),
    .plane_done(plane_done)
  );

  logic [MODE_BITS-1:0] mode_reg   = MODE_MAX;
  logic [WIN_BITS-1:0]  win_reg    = RST_WINDOW_SIZE;
  logic [WIN_BITS-1:0]  step_reg   = RST_STEP_SIZE;
  logic [SIZE_BITS-1:0] width_reg  = RST_PLANE_WIDTH;
  logic [SIZE_BITS-1:0] height_reg = RST_PLANE_HEIGHT;

  logic signed [15:0] line_rows [WIN_MAX][ROW_MAX];
  int row_at  = 0;
  int col_at  = 0;
  int slot_at = 0;

  pool_result_t windows_due[$];
  script_row_t  script[$];
  pool_result_t oldest;
  int errors       = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  bit steady       = 1'b0;
  bit hold_long    = 1'b0;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic int eff_size(input int raw);
    if (raw < 1) return 1;
    if (raw > ROW_MAX) return ROW_MAX;
    return raw;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_POOL_MODE:    mode_reg = data[MODE_BITS-1:0];
      REG_WINDOW_SIZE:  win_reg = data[WIN_BITS-1:0];
      REG_STEP_SIZE:    step_reg = data[WIN_BITS-1:0];
      REG_PLANE_WIDTH:  width_reg = data;
      REG_PLANE_HEIGHT: height_reg = data;
      default: ;
    endcase
  endfunction

  // Stores the pixel, then pools the window whose bottom-right corner it is, if its origin lies on the stride grid.
  function automatic bit pool_next_pixel(input logic [15:0] px, output pool_result_t res);
    int ws, st, w, h, r, c, orow, ocol, k, j;
    longint acc, v;
    bit first, hit;
    ws = (win_reg > WIN_MAX) ? WIN_MAX : ((win_reg == 0) ? 1 : int'(win_reg));
    st = (step_reg == 0) ? 1 : int'(step_reg);
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    r = row_at;
    c = col_at;
    hit = 1'b0;
    res = '0;
    line_rows[slot_at][c] = px;
    if (r + 1 >= ws && c + 1 >= ws && (r + 1 - ws) % st == 0 && (c + 1 - ws) % st == 0) begin
      hit = 1'b1;
      orow = (r + 1 - ws) / st;
      ocol = (c + 1 - ws) / st;
      first = 1'b1;
      acc = 0;
      for (k = 0; k < ws; k++) begin
        for (j = 0; j < ws; j++) begin
          v = line_rows[(slot_at + WIN_MAX - k) % WIN_MAX][c - j];
          if (first) begin
            acc = v;
            first = 1'b0;
          end else if (mode_reg == MODE_MIN) begin
            if (v < acc) acc = v;
          end else if (mode_reg == MODE_AVG) begin
            acc += v;
          end else begin
            if (v > acc) acc = v;
          end
        end
      end
      if (mode_reg == MODE_AVG) acc = acc / (ws * ws);
      res.value = acc[15:0];
      res.row = orow[POS_BITS-1:0];
      res.col = ocol[POS_BITS-1:0];
      res.done = (h >= ws && w >= ws && orow == (h - ws) / st && ocol == (w - ws) / st);
    end
    if (c + 1 >= w) begin
      col_at = 0;
      if (r + 1 >= h) begin
        row_at = 0;
        slot_at = 0;
      end else begin
        row_at = (r + 1) & (ROW_MAX - 1);
        slot_at = (slot_at + 1) % WIN_MAX;
      end
    end else begin
      col_at = c + 1;
    end
    return hit;
  endfunction

  function automatic logic [15:0] any_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic script_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] data);
    script.push_back('{1'b1, idx, data, 16'h0000, 1'b0, '0});
  endtask

  task automatic script_pixel(input logic [15:0] px);
    script.push_back('{1'b0, REG_POOL_MODE, 7'd0, px, 1'b0, '0});
  endtask

  task automatic script_window(input logic [15:0] px, input logic [15:0] value,
                               input logic [POS_BITS-1:0] row, input logic [POS_BITS-1:0] col,
                               input logic done);
    script.push_back('{1'b0, REG_POOL_MODE, 7'd0, px, 1'b1, '{value, row, col, done}});
  endtask

  task automatic offer_pixel(input logic [15:0] px, input logic typed, input pool_result_t want);
    pool_result_t due;
    bit produced;
    @(negedge clk);
    if (!steady && $urandom_range(1, 100) <= gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel_in = px;
    do @(posedge clk); while (!in_ready);
    produced = pool_next_pixel(px, due);
    if (typed) windows_due.push_back(want);
    else if (produced) windows_due.push_back(due);
    items_sent++;
  endtask

  task automatic feed_pixels(input int count);
    repeat (count) offer_pixel(any_pixel(), 1'b0, '0);
  endtask

  // The sequencer may still be busy on a pixel that closes no window.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (windows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic set_plane(input logic [6:0] mode_d, input logic [6:0] win_d,
                           input logic [6:0] step_d, input logic [6:0] w_d,
                           input logic [6:0] h_d);
    write_reg(REG_POOL_MODE, mode_d);
    write_reg(REG_WINDOW_SIZE, win_d);
    write_reg(REG_STEP_SIZE, step_d);
    write_reg(REG_PLANE_WIDTH, w_d);
    write_reg(REG_PLANE_HEIGHT, h_d);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
        out_ready = 1'b1;
      end else if (!steady && $urandom_range(1, 100) <= stall_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (windows_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got value %h row %0d col %0d done %0d",
                 $time, pooled_value, out_row, out_col, plane_done);
        errors++;
      end else begin
        oldest = windows_due.pop_front();
        if (pooled_value !== oldest.value) begin
          $display("%0t: pooled_value expected %h got %h", $time, oldest.value, pooled_value);
          errors++;
        end
        if (out_row !== oldest.row) begin
          $display("%0t: out_row expected %0d got %0d", $time, oldest.row, out_row);
          errors++;
        end
        if (out_col !== oldest.col) begin
          $display("%0t: out_col expected %0d got %0d", $time, oldest.col, out_col);
          errors++;
        end
        if (plane_done !== oldest.done) begin
          $display("%0t: plane_done expected %0d got %0d", $time, oldest.done, plane_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int area;
    int count;
    logic [6:0] w_raw;
    logic [6:0] h_raw;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_POOL_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel_in = '0;

    // Two by two planes with the reset window and stride, for every pooling mode code.
    script_reg(REG_PLANE_WIDTH, 7'd2);
    script_reg(REG_PLANE_HEIGHT, 7'd2);
    script_pixel(16'h7FFF);
    script_pixel(16'h8000);
    script_pixel(16'h0001);
    script_window(16'hFFFF, 16'h7FFF, 6'd0, 6'd0, 1'b1);
    script_reg(REG_POOL_MODE, 7'(MODE_MIN));
    script_pixel(16'h0100);
    script_pixel(16'h8000);
    script_pixel(16'h7FFF);
    script_window(16'h0000, 16'h8000, 6'd0, 6'd0, 1'b1);
    // The average truncates toward zero, and the sum needs more than sixteen bits.
    script_reg(REG_POOL_MODE, 7'(MODE_AVG));
    script_pixel(16'hFFFF);
    script_pixel(16'hFFFF);
    script_pixel(16'hFFFF);
    script_window(16'hFFFE, 16'hFFFF, 6'd0, 6'd0, 1'b1);
    script_pixel(16'h8000);
    script_pixel(16'h8000);
    script_pixel(16'h8000);
    script_window(16'h7FFF, 16'hC000, 6'd0, 6'd0, 1'b1);
    script_reg(REG_POOL_MODE, 7'(MODE_ALIAS_MAX));
    script_pixel(16'h0005);
    script_pixel(16'h0003);
    script_pixel(16'hFFF9);
    script_window(16'h0002, 16'h0005, 6'd0, 6'd0, 1'b1);
    // A zero window and a zero stride act as one.
    script_reg(REG_POOL_MODE, 7'(MODE_MAX));
    script_reg(REG_WINDOW_SIZE, 7'd0);
    script_reg(REG_STEP_SIZE, 7'd0);
    script_reg(REG_PLANE_HEIGHT, 7'd1);
    script_window(16'h1234, 16'h1234, 6'd0, 6'd0, 1'b0);
    script_window(16'h8000, 16'h8000, 6'd0, 6'd1, 1'b1);
    // An oversized window on a zero-width plane yields nothing.
    script_reg(REG_WINDOW_SIZE, 7'd7);
    script_reg(REG_STEP_SIZE, 7'd4);
    script_reg(REG_PLANE_WIDTH, 7'd0);
    script_pixel(16'h00FF);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        wait_idle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        offer_pixel(script[i].px, script[i].typed, script[i].want);
      end
    end

    // One full plane of the widest size writes every line store entry, so later
    // size changes in the middle of a plane never read an unwritten entry.
    wait_idle();
    gap_pct = 10;
    stall_pct = 10;
    set_plane(7'($urandom_range(0, 127)), 7'd4, 7'($urandom_range(1, 4)), 7'd100, 7'd4);
    feed_pixels(ROW_MAX * WIN_MAX);

    // Every pixel closes a window while the receiver holds off for a long time.
    wait_idle();
    gap_pct = 0;
    set_plane(7'($urandom_range(0, 127)), 7'd1, 7'd1, 7'd8, 7'd8);
    hold_long = 1'b1;
    feed_pixels(64);

    while (items_sent < PIXEL_TARGET) begin
      wait_idle();
      if (PIXEL_TARGET - items_sent < STEADY_TAIL) steady = 1'b1;
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
      case ($urandom_range(0, 9))
        0: begin
          w_raw = $urandom_range(0, 1) ? 7'd127 : 7'($urandom_range(64, 126));
          h_raw = 7'($urandom_range(0, 2));
        end
        1: begin
          h_raw = $urandom_range(0, 1) ? 7'd127 : 7'($urandom_range(64, 126));
          w_raw = 7'($urandom_range(0, 2));
        end
        default: begin
          w_raw = 7'($urandom_range(0, 12));
          h_raw = 7'($urandom_range(0, 12));
        end
      endcase
      set_plane(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), w_raw, h_raw);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_SPARE + 3'($urandom_range(0, 2)), 7'($urandom_range(0, 127)));
      end
      area = eff_size(w_raw) * eff_size(h_raw);
      count = area * $urandom_range(1, 2);
      // Sometimes stop inside a plane so the next settings start mid-plane.
      if ($urandom_range(0, 2) == 0) count += $urandom_range(1, area);
      if (count > PIXEL_TARGET - items_sent) count = PIXEL_TARGET - items_sent;
      feed_pixels(count);
    end

    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
